// ===== hdl/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumH = 8;
  localparam int unsigned NumW = 16;
  localparam int unsigned NumRounds = 64;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [0:0] ActAbsorb = 1'b0;
  localparam logic [0:0] ActFinal = 1'b1;

  typedef logic [WordW-1:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     put_byte;   // write a byte into the block buffer
    logic     put_pad;    // write the pad byte and clear the rest of the block
    logic     put_len;    // write the length into words 14 and 15
    logic     clr_block;  // clear all sixteen words
    logic     start_comp; // load working variables, begin rounds
    logic     round;      // run one round
    logic     add_hash;   // fold working variables into hash words
    logic     reset_msg;  // restore initial hash, length and count
    logic     shift_out;  // rotate hash words to present next digest word
  } sha_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic [5:0] bytes_in_block;
    logic       last_round;
  } sha_stat_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    case (i)
      6'd0: round_k = 32'h428a2f98;  6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hb5c0fbcf;  6'd3: round_k = 32'he9b5dba5;
      6'd4: round_k = 32'h3956c25b;  6'd5: round_k = 32'h59f111f1;
      6'd6: round_k = 32'h923f82a4;  6'd7: round_k = 32'hab1c5ed5;
      6'd8: round_k = 32'hd807aa98;  6'd9: round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7; 6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      3'd7: init_h = 32'h5be0cd19;
      default: init_h = 32'h0;
    endcase
  endfunction

endpackage

// ===== hdl/sha256_byte_stream_hash.sv =====
// SHA-256 engine fed one message byte per request. An absorb request
// (action 0) packs its byte big-endian into a 64-byte block; the request
// that completes a block also starts the compression, which runs one
// round per cycle for all 64 rounds and then adds into the hash words;
// in_stall holds off new requests until it is done. A finalize request
// (action 1) appends standard padding and the 64-bit bit length,
// compresses once (or twice when 56 or more bytes of the last block
// were held), and then offers the eight digest words on the result
// channel, word 0 first, with last_word on word 7. The round loop is the
// single shared compression unit, and the block buffer doubles as the
// sliding message-schedule window. After the eighth word is taken the
// engine is back at its initial values and ready for a new message.
module sha256_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_action      (in_action),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .stat           (stat),
    .cmd            (cmd)
  );

  sha256_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .byte_in   (in_data_byte),
    .stat      (stat),
    .head_word (out_digest_word)
  );

endmodule

// ===== hdl/sha256_dp.sv =====
module sha256_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::sha_cmd_t  cmd,
  input  logic [7:0]            byte_in,
  output sha256_pkg::sha_stat_t stat,
  output sha256_pkg::word_t     head_word
);
  import sha256_pkg::*;

  word_t       hash_r [NumH];
  word_t       hash_nxt [NumH];
  word_t       blk_r [NumW];
  word_t       blk_nxt [NumW];
  word_t       var_r [NumH];
  word_t       var_nxt [NumH];
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  rnd_r, rnd_nxt;

  word_t s0, s1, w_new, t1, t2, e, a;
  logic [3:0] wi;
  logic [1:0] bi;

  assign wi = cnt_r[5:2];
  assign bi = cnt_r[1:0];
  assign e  = var_r[4];
  assign a  = var_r[0];
  // The block buffer acts as a 16-word schedule window: word 0 is w[t].
  assign s0 = rotr(blk_r[1], 7) ^ rotr(blk_r[1], 18) ^ (blk_r[1] >> 3);
  assign s1 = rotr(blk_r[14], 17) ^ rotr(blk_r[14], 19) ^ (blk_r[14] >> 10);
  assign w_new = s1 + blk_r[9] + s0 + blk_r[0];
  assign t1 = var_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & var_r[5]) ^ (~e & var_r[6])) + round_k(rnd_r) + blk_r[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & var_r[1]) ^ (a & var_r[2]) ^ (var_r[1] & var_r[2]));

  assign stat.bytes_in_block = cnt_r;
  assign stat.last_round = (rnd_r == 6'(NumRounds - 1));
  assign head_word = hash_r[0];

  always_comb begin
    word_t  wv;
    logic [7:0] bv;
    hash_nxt = hash_r;
    blk_nxt  = blk_r;
    var_nxt  = var_r;
    cnt_nxt  = cnt_r;
    bits_nxt = bits_r;
    rnd_nxt  = rnd_r;
    bv = cmd.put_pad ? PadByte : byte_in;
    if (cmd.put_byte || cmd.put_pad) begin
      wv = (bi == 2'd0) ? '0 : blk_r[wi];
      case (bi)
        2'd0: wv[31:24] = bv;
        2'd1: wv[23:16] = bv;
        2'd2: wv[15:8]  = bv;
        default: wv[7:0] = bv;
      endcase
      blk_nxt[wi] = wv;
    end
    if (cmd.put_byte) begin
      cnt_nxt  = cnt_r + 6'd1;
      bits_nxt = bits_r + 64'd8;
    end
    if (cmd.put_pad) begin
      for (int k = 0; k < NumW; k++) begin
        if (4'(k) > wi) blk_nxt[k] = '0;
      end
    end
    if (cmd.clr_block) begin
      for (int k = 0; k < NumW; k++) blk_nxt[k] = '0;
    end
    if (cmd.put_len) begin
      blk_nxt[14] = bits_r[63:32];
      blk_nxt[15] = bits_r[31:0];
    end
    if (cmd.start_comp) begin
      var_nxt = hash_r;
      rnd_nxt = '0;
    end
    if (cmd.round) begin
      for (int k = 0; k < NumW - 1; k++) blk_nxt[k] = blk_r[k+1];
      blk_nxt[NumW-1] = w_new;
      var_nxt[7] = var_r[6];
      var_nxt[6] = var_r[5];
      var_nxt[5] = var_r[4];
      var_nxt[4] = var_r[3] + t1;
      var_nxt[3] = var_r[2];
      var_nxt[2] = var_r[1];
      var_nxt[1] = var_r[0];
      var_nxt[0] = t1 + t2;
      rnd_nxt = rnd_r + 6'd1;
    end
    if (cmd.add_hash) begin
      for (int k = 0; k < NumH; k++) hash_nxt[k] = hash_r[k] + var_r[k];
    end
    if (cmd.shift_out) begin
      for (int k = 0; k < NumH - 1; k++) hash_nxt[k] = hash_r[k+1];
      hash_nxt[NumH-1] = hash_r[0];
    end
    if (cmd.reset_msg) begin
      for (int k = 0; k < NumH; k++) hash_nxt[k] = init_h(3'(k));
      cnt_nxt  = '0;
      bits_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    var_r <= var_nxt;
    rnd_r <= rnd_nxt;
    if (!rst_n) begin
      for (int k = 0; k < NumH; k++) hash_r[k] <= init_h(3'(k));
      cnt_r  <= '0;
      bits_r <= '0;
    end else begin
      hash_r <= hash_nxt;
      cnt_r  <= cnt_nxt;
      bits_r <= bits_nxt;
    end
  end

endmodule

// ===== hdl/sha256_ctrl.sv =====
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_action,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word,
  input  sha256_pkg::sha_stat_t stat,
  output sha256_pkg::sha_cmd_t  cmd
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_LEN,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic       final_r;   // the running compression belongs to a finalize
  logic       spill_r;   // a length-only block still follows
  logic [2:0] idx_r;
  logic       acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign out_valid = (state_r == S_EMIT);
  assign out_word_index = idx_r;
  assign out_last_word = (idx_r == 3'd7);

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_action == ActAbsorb) begin
            cmd.put_byte = 1'b1;
            cmd.start_comp = (stat.bytes_in_block == 6'd63);
          end else begin
            cmd.put_pad = 1'b1;
            cmd.start_comp = 1'b1;
            cmd.put_len = (stat.bytes_in_block < 6'd56);
          end
        end
      end
      S_ROUND: cmd.round = 1'b1;
      S_ADD:   cmd.add_hash = 1'b1;
      S_LEN: begin
        cmd.clr_block = 1'b1;
        cmd.put_len = 1'b1;
        cmd.start_comp = 1'b1;
      end
      S_EMIT: begin
        if (!out_stall) begin
          cmd.shift_out = 1'b1;
          cmd.reset_msg = (idx_r == 3'd7);
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      final_r <= 1'b0;
      spill_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (in_action == ActAbsorb) begin
              final_r <= 1'b0;
              spill_r <= 1'b0;
              if (stat.bytes_in_block == 6'd63) state_r <= S_ROUND;
            end else begin
              final_r <= 1'b1;
              spill_r <= (stat.bytes_in_block >= 6'd56);
              state_r <= S_ROUND;
            end
          end
        end
        S_ROUND: if (stat.last_round) state_r <= S_ADD;
        S_ADD: begin
          if (!final_r) begin
            state_r <= S_IDLE;
          end else if (spill_r) begin
            spill_r <= 1'b0;
            state_r <= S_LEN;
          end else begin
            idx_r   <= '0;
            state_r <= S_EMIT;
          end
        end
        // The length-only block is loaded here, after the S_ADD write.
        S_LEN: state_r <= S_ROUND;
        S_EMIT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sha256_checker.sv =====
module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word does not match word index");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word))
    else $error("stalled result changed");

  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words not consecutive");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest pending");

endmodule

bind sha256_byte_stream_hash sha256_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);
